[src/chs_pkg.sv]
// shared types, codes and the opcode table of the cartridge header scorer
// no dependencies
`default_nettype none

package chs_pkg;

  localparam int SLOT_W  = 2;
  localparam int SCORE_W = 5;
  localparam int CHOSEN_W = 2;
  localparam int SIZE_W  = 24;

  // candidate slots
  localparam logic [SLOT_W-1:0] SLOT_LOW  = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_HIGH = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_EXT  = 2'd2;

  // chosen location codes
  localparam logic [CHOSEN_W-1:0] CHOSEN_NONE = 2'd0;
  localparam logic [CHOSEN_W-1:0] CHOSEN_LOW  = 2'd1;
  localparam logic [CHOSEN_W-1:0] CHOSEN_HIGH = 2'd2;
  localparam logic [CHOSEN_W-1:0] CHOSEN_EXT  = 2'd3;

  // header location plus 64 bytes: smallest image that holds the header
  localparam logic [SIZE_W-1:0] MIN_SIZE_LOW  = 24'h008000;
  localparam logic [SIZE_W-1:0] MIN_SIZE_HIGH = 24'h010000;
  localparam logic [SIZE_W-1:0] MIN_SIZE_EXT  = 24'h410000;

  localparam logic [15:0] VECTOR_MIN    = 16'h8000;
  localparam logic [16:0] CHECKSUM_SUM  = 17'h0ffff;
  localparam logic [7:0]  MAP_MASK      = 8'hef;
  localparam logic [7:0]  MAKER_EXT     = 8'h33;
  localparam logic [SCORE_W-1:0] EXT_BONUS = 5'd4;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [15:0]       reset_vector;
    logic [7:0]        reset_opcode;
    logic [15:0]       checksum_word;
    logic [15:0]       complement_word;
    logic [7:0]        map_mode;
    logic [7:0]        maker_code;
    logic [7:0]        cart_type;
    logic [7:0]        rom_size_code;
    logic [7:0]        ram_size_code;
    logic [7:0]        region_code;
  } record_t;

  typedef struct packed {
    logic                decided;
    logic [CHOSEN_W-1:0] chosen_location;
  } choice_t;

  // points for the first instruction executed after reset
  function automatic logic signed [4:0] opcode_points(input logic [7:0] op);
    logic signed [4:0] pts;
    case (op)
      8'h78, 8'h18, 8'h38, 8'h9c, 8'h4c, 8'h5c: pts = 5'sd8;
      8'hc2, 8'he2, 8'had, 8'hae, 8'hac, 8'haf,
      8'ha9, 8'ha2, 8'ha0, 8'h20, 8'h22: pts = 5'sd4;
      8'h40, 8'h60, 8'h6b, 8'hcd, 8'hec, 8'hcc: pts = -5'sd4;
      8'h00, 8'h02, 8'hdb, 8'h42, 8'hff: pts = -5'sd8;
      default: pts = 5'sd0;
    endcase
    return pts;
  endfunction

endpackage

`default_nettype wire

[src/chs_if.sv]
// channel interfaces of the cartridge header scorer: header records in, scores out
// depends on chs_pkg
`default_nettype none

interface chs_record_if;
  logic                       valid;
  logic                       ready;
  logic [chs_pkg::SLOT_W-1:0] slot;
  logic [15:0]                reset_vector;
  logic [7:0]                 reset_opcode;
  logic [15:0]                checksum_word;
  logic [15:0]                complement_word;
  logic [7:0]                 map_mode;
  logic [7:0]                 maker_code;
  logic [7:0]                 cart_type;
  logic [7:0]                 rom_size_code;
  logic [7:0]                 ram_size_code;
  logic [7:0]                 region_code;

  modport source (
    output valid, slot, reset_vector, reset_opcode, checksum_word, complement_word,
           map_mode, maker_code, cart_type, rom_size_code, ram_size_code, region_code,
    input  ready
  );
  modport sink (
    input  valid, slot, reset_vector, reset_opcode, checksum_word, complement_word,
           map_mode, maker_code, cart_type, rom_size_code, ram_size_code, region_code,
    output ready
  );
endinterface

interface chs_result_if;
  logic                         valid;
  logic                         ready;
  logic [chs_pkg::SCORE_W-1:0]  score;
  logic                         decided;
  logic [chs_pkg::CHOSEN_W-1:0] chosen_location;

  modport source (output valid, score, decided, chosen_location, input ready);
  modport sink   (input valid, score, decided, chosen_location, output ready);
endinterface

`default_nettype wire

[src/cartridge_header_scorer.sv]
// top level of the cartridge header scorer: input register, rater, chooser, result register
// depends on chs_pkg, chs_if, chs_rater, chs_chooser
`default_nettype none

// Takes one header record per cycle while the result side is not stalled and returns
// one score transaction per record. The record is registered, scored by a single pass
// of compare-and-add logic and registered again at the output, so a new record is
// taken every cycle unless the result side stalls. The low and high scores are
// held and used by the extended-high record to report the chosen location. A record
// in slot three gives an all-zero result and leaves the held scores alone. Write
// image_size only while no record is in flight.
module cartridge_header_scorer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wen,
  input  wire logic [chs_pkg::SIZE_W-1:0]    cfg_wdata,
  chs_record_if.sink                         records,
  chs_result_if.source                       results
);

  logic [chs_pkg::SIZE_W-1:0]  image_size;
  logic [chs_pkg::SCORE_W-1:0] low_slot_score;
  logic [chs_pkg::SCORE_W-1:0] high_slot_score;

  logic                        rec_valid;
  chs_pkg::record_t            rec;
  logic                        advance;

  logic [chs_pkg::SCORE_W-1:0] score;
  chs_pkg::choice_t            choice;

  logic                        out_valid;
  logic [chs_pkg::SCORE_W-1:0] out_score;
  chs_pkg::choice_t            out_choice;

  assign advance       = rec_valid && (!out_valid || results.ready);
  assign records.ready = !rec_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= '0;
    end else if (cfg_wen) begin
      image_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (records.ready) begin
      rec_valid <= records.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (records.valid && records.ready) begin
      rec.slot            <= records.slot;
      rec.reset_vector    <= records.reset_vector;
      rec.reset_opcode    <= records.reset_opcode;
      rec.checksum_word   <= records.checksum_word;
      rec.complement_word <= records.complement_word;
      rec.map_mode        <= records.map_mode;
      rec.maker_code      <= records.maker_code;
      rec.cart_type       <= records.cart_type;
      rec.rom_size_code   <= records.rom_size_code;
      rec.ram_size_code   <= records.ram_size_code;
      rec.region_code     <= records.region_code;
    end
  end

  chs_rater u_rater (
    .rec        (rec),
    .image_size (image_size),
    .score      (score)
  );

  chs_chooser u_chooser (
    .slot            (rec.slot),
    .score           (score),
    .low_slot_score  (low_slot_score),
    .high_slot_score (high_slot_score),
    .choice          (choice)
  );

  // held scores follow record order since they update as a record leaves the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      low_slot_score  <= '0;
      high_slot_score <= '0;
    end else if (advance) begin
      if (rec.slot == chs_pkg::SLOT_LOW) begin
        low_slot_score <= score;
      end
      if (rec.slot == chs_pkg::SLOT_HIGH) begin
        high_slot_score <= score;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_score  <= score;
      out_choice <= choice;
    end
  end

  assign results.valid           = out_valid;
  assign results.score           = out_score;
  assign results.decided         = out_choice.decided;
  assign results.chosen_location = out_choice.chosen_location;

endmodule

`default_nettype wire

[src/chs_rater.sv]
// plausibility score of one header record, 0 to 20
// depends on chs_pkg
`default_nettype none

module chs_rater (
  input  wire chs_pkg::record_t                 rec,
  input  wire logic [chs_pkg::SIZE_W-1:0]       image_size,
  output logic [chs_pkg::SCORE_W-1:0]           score
);

  logic [chs_pkg::SIZE_W-1:0] min_size;
  logic                       slot_ok;
  logic                       too_small;
  logic [16:0]                chk_sum;
  logic [7:0]                 map;
  logic                       map_fits;
  logic signed [5:0]          total;

  always_comb begin
    slot_ok  = 1'b1;
    map      = rec.map_mode & chs_pkg::MAP_MASK;
    map_fits = 1'b0;
    case (rec.slot)
      chs_pkg::SLOT_LOW: begin
        min_size = chs_pkg::MIN_SIZE_LOW;
        map_fits = (map == 8'h20) || (map == 8'h22);
      end
      chs_pkg::SLOT_HIGH: begin
        min_size = chs_pkg::MIN_SIZE_HIGH;
        map_fits = (map == 8'h21);
      end
      chs_pkg::SLOT_EXT: begin
        min_size = chs_pkg::MIN_SIZE_EXT;
        map_fits = (map == 8'h25);
      end
      default: begin
        min_size = chs_pkg::MIN_SIZE_EXT;
        slot_ok  = 1'b0;
      end
    endcase
  end

  assign too_small = image_size < min_size;
  // unwrapped sum of checksum and complement
  assign chk_sum = {1'b0, rec.checksum_word} + {1'b0, rec.complement_word};

  always_comb begin
    total = 6'(chs_pkg::opcode_points(rec.reset_opcode));
    if (chk_sum == chs_pkg::CHECKSUM_SUM && rec.checksum_word != 16'h0 &&
        rec.complement_word != 16'h0) begin
      total = total + 6'sd4;
    end
    if (map_fits) begin
      total = total + 6'sd2;
    end
    if (rec.maker_code == chs_pkg::MAKER_EXT) begin
      total = total + 6'sd2;
    end
    total = total + 6'($unsigned(rec.cart_type < 8'h08))
                  + 6'($unsigned(rec.rom_size_code < 8'h10))
                  + 6'($unsigned(rec.ram_size_code < 8'h08))
                  + 6'($unsigned(rec.region_code < 8'd14));
  end

  always_comb begin
    if (!slot_ok || too_small || rec.reset_vector < chs_pkg::VECTOR_MIN || total[5]) begin
      score = '0;
    end else begin
      score = total[chs_pkg::SCORE_W-1:0];
    end
  end

endmodule

`default_nettype wire

[src/chs_chooser.sv]
// picks the winning header location on the extended-high record
// depends on chs_pkg
`default_nettype none

module chs_chooser (
  input  wire logic [chs_pkg::SLOT_W-1:0]  slot,
  input  wire logic [chs_pkg::SCORE_W-1:0] score,
  input  wire logic [chs_pkg::SCORE_W-1:0] low_slot_score,
  input  wire logic [chs_pkg::SCORE_W-1:0] high_slot_score,
  output chs_pkg::choice_t                 choice
);

  logic [chs_pkg::SCORE_W-1:0] ext_score;

  // bonus only for a nonzero extended score; max 24 still fits
  assign ext_score = (score != '0) ? score + chs_pkg::EXT_BONUS : '0;

  always_comb begin
    choice.decided         = 1'b0;
    choice.chosen_location = chs_pkg::CHOSEN_NONE;
    if (slot == chs_pkg::SLOT_EXT) begin
      choice.decided = 1'b1;
      if (low_slot_score >= high_slot_score && low_slot_score >= ext_score) begin
        choice.chosen_location = chs_pkg::CHOSEN_LOW;
      end else if (high_slot_score >= ext_score) begin
        choice.chosen_location = chs_pkg::CHOSEN_HIGH;
      end else if (ext_score > chs_pkg::EXT_BONUS) begin
        choice.chosen_location = chs_pkg::CHOSEN_EXT;
      end
    end
  end

endmodule

`default_nettype wire

[tb/sv/chs_score_checker.sv]
`timescale 1ns / 100ps
// score checker for the cartridge header scorer: watches the record, result and
// configuration ports, predicts each result and compares it; depends on chs_pkg, chs_if

module chs_score_checker
  import chs_pkg::*;
#(
  parameter int OPCODE_COUNT = 28,
  parameter logic [OPCODE_COUNT*8-1:0] OPCODES = '0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wen,
  input  wire logic [SIZE_W-1:0] cfg_wdata,
  chs_record_if                  records,
  chs_result_if                  results,
  output int                     mismatches,
  output int                     pending
);

  // opcode list is grouped: +8 entries, then +4, then -4, then -8
  localparam int END_PLUS8  = 6;
  localparam int END_PLUS4  = 17;
  localparam int END_MINUS4 = 23;

  localparam logic [24:0] LOC_LOW  = 25'h0007fc0;
  localparam logic [24:0] LOC_HIGH = 25'h000ffc0;
  localparam logic [24:0] LOC_EXT  = 25'h040ffc0;
  localparam logic [24:0] HEADER_BYTES = 25'd64;
  localparam logic [15:0] VECTOR_FLOOR = 16'h8000;
  localparam logic [SCORE_W:0] EXT_LEAD = 6'd4;

  typedef struct packed {
    logic [SCORE_W-1:0]  score;
    logic                decided;
    logic [CHOSEN_W-1:0] location;
  } rating_t;

  rating_t           ratings_due[$];
  logic [SIZE_W-1:0] image_size;
  logic [SCORE_W-1:0] low_score;
  logic [SCORE_W-1:0] high_score;
  int                errs = 0;

  assign mismatches = errs;

  function automatic int opcode_weight(input logic [7:0] op);
    int w;
    w = 0;
    for (int i = 0; i < OPCODE_COUNT; i++) begin
      if (OPCODES[(OPCODE_COUNT-1-i)*8 +: 8] == op) begin
        w = (i < END_PLUS8) ? 8 : (i < END_PLUS4) ? 4 : (i < END_MINUS4) ? -4 : -8;
      end
    end
    return w;
  endfunction

  function automatic logic [SCORE_W-1:0] header_points(input record_t r,
                                                       input logic [SIZE_W-1:0] size);
    logic [24:0] need;
    logic [16:0] sum;
    logic [7:0]  mapper;
    int          pts;
    case (r.slot)
      SLOT_LOW:  need = LOC_LOW + HEADER_BYTES;
      SLOT_HIGH: need = LOC_HIGH + HEADER_BYTES;
      default:   need = LOC_EXT + HEADER_BYTES;
    endcase
    if ({1'b0, size} < need || r.reset_vector < VECTOR_FLOOR) return '0;
    pts = opcode_weight(r.reset_opcode);
    // full 17-bit sum, no wrap
    sum = {1'b0, r.checksum_word} + {1'b0, r.complement_word};
    if (sum == 17'h0ffff && r.checksum_word != 0 && r.complement_word != 0) pts += 4;
    mapper = r.map_mode & 8'hef;
    if (r.slot == SLOT_LOW && (mapper == 8'h20 || mapper == 8'h22)) pts += 2;
    if (r.slot == SLOT_HIGH && mapper == 8'h21) pts += 2;
    if (r.slot == SLOT_EXT && mapper == 8'h25) pts += 2;
    if (r.maker_code == 8'h33) pts += 2;
    if (r.cart_type < 8'h08) pts += 1;
    if (r.rom_size_code < 8'h10) pts += 1;
    if (r.ram_size_code < 8'h08) pts += 1;
    if (r.region_code < 8'd14) pts += 1;
    if (pts < 0) pts = 0;
    return pts[SCORE_W-1:0];
  endfunction

  always @(posedge clk) begin : track
    record_t             rec;
    logic [SCORE_W-1:0]  pts;
    logic [SCORE_W:0]    ext_pts;
    rating_t             want;
    rating_t             got;
    if (rst) begin
      image_size = '0;
      low_score  = '0;
      high_score = '0;
      ratings_due.delete();
    end else begin
      if (cfg_wen) image_size = cfg_wdata;
      if (records.valid && records.ready) begin
        rec = {records.slot, records.reset_vector, records.reset_opcode,
               records.checksum_word, records.complement_word, records.map_mode,
               records.maker_code, records.cart_type, records.rom_size_code,
               records.ram_size_code, records.region_code};
        pts = header_points(rec, image_size);
        want.score    = pts;
        want.decided  = 1'b0;
        want.location = CHOSEN_NONE;
        case (rec.slot)
          SLOT_LOW:  low_score = pts;
          SLOT_HIGH: high_score = pts;
          SLOT_EXT: begin
            ext_pts = (pts == 0) ? '0 : {1'b0, pts} + EXT_LEAD;
            want.decided = 1'b1;
            if ({1'b0, low_score} >= {1'b0, high_score} && {1'b0, low_score} >= ext_pts) begin
              want.location = CHOSEN_LOW;
            end else if ({1'b0, high_score} >= ext_pts) begin
              want.location = CHOSEN_HIGH;
            end else if (ext_pts > EXT_LEAD) begin
              want.location = CHOSEN_EXT;
            end
          end
          // unused selector: blank result, held scores untouched
          default: want.score = '0;
        endcase
        ratings_due.push_back(want);
      end
      if (results.valid && results.ready) begin
        got = {results.score, results.decided, results.chosen_location};
        if (ratings_due.size() == 0) begin
          $display("%0t: unexpected result transaction: score %0d decided %0b location %0d",
                   $time, got.score, got.decided, got.location);
          errs++;
        end else begin
          want = ratings_due.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch: expected score %0d decided %0b location %0d,",
                     $time, want.score, want.decided, want.location);
            $display("%0t:           actual   score %0d decided %0b location %0d",
                     $time, got.score, got.decided, got.location);
            errs++;
          end
        end
      end
    end
    pending <= ratings_due.size();
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// top of the cartridge header scorer testbench: clock, reset, image size writes,
// record stimulus, result back-pressure and verdict; depends on chs_pkg, chs_if,
// cartridge_header_scorer and chs_score_checker

module testbench;
  import chs_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 120;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 72;
  localparam int OPCODE_COUNT = 28;
  // scored first opcodes, grouped +8, +4, -4, -8
  localparam logic [OPCODE_COUNT*8-1:0] SCORED_OPCODES = {
    8'h78, 8'h18, 8'h38, 8'h9c, 8'h4c, 8'h5c,
    8'hc2, 8'he2, 8'had, 8'hae, 8'hac, 8'haf, 8'ha9, 8'ha2, 8'ha0, 8'h20, 8'h22,
    8'h40, 8'h60, 8'h6b, 8'hcd, 8'hec, 8'hcc,
    8'h00, 8'h02, 8'hdb, 8'h42, 8'hff
  };
  localparam logic [SLOT_W-1:0] SLOT_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_wen;
  logic [SIZE_W-1:0] cfg_wdata;
  logic              quiet;
  logic              hold_go;
  int                mismatches;
  int                pending;

  chs_record_if rec_ch ();
  chs_result_if res_ch ();

  cartridge_header_scorer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .records   (rec_ch),
    .results   (res_ch)
  );

  chs_score_checker #(
    .OPCODE_COUNT (OPCODE_COUNT),
    .OPCODES      (SCORED_OPCODES)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .records    (rec_ch),
    .results    (res_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // result side: random stalls, one long hold-off once requested
  initial begin : result_sink
    int held;
    held = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && held < HOLD_CYCLES) begin
        res_ch.ready <= 1'b0;
        held++;
      end else begin
        res_ch.ready <= quiet || $urandom_range(99) >= 10;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  task automatic put_fields(input record_t r);
    rec_ch.slot            <= r.slot;
    rec_ch.reset_vector    <= r.reset_vector;
    rec_ch.reset_opcode    <= r.reset_opcode;
    rec_ch.checksum_word   <= r.checksum_word;
    rec_ch.complement_word <= r.complement_word;
    rec_ch.map_mode        <= r.map_mode;
    rec_ch.maker_code      <= r.maker_code;
    rec_ch.cart_type       <= r.cart_type;
    rec_ch.rom_size_code   <= r.rom_size_code;
    rec_ch.ram_size_code   <= r.ram_size_code;
    rec_ch.region_code     <= r.region_code;
  endtask

  // returns at the edge where the transaction is taken
  task automatic send_record(input record_t r);
    while (!quiet && $urandom_range(99) < 10) begin
      rec_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rec_ch.valid <= 1'b1;
    put_fields(r);
    @(posedge clk);
    while (!rec_ch.ready) @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] size);
    cfg_wen   <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  task automatic settle(input int extra);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  function automatic record_t header_rec(
    input logic [1:0] slot, input logic [15:0] vec, input logic [7:0] op,
    input logic [15:0] chk, input logic [15:0] cmp, input logic [7:0] mapper,
    input logic [7:0] maker, input logic [7:0] ct, input logic [7:0] rom,
    input logic [7:0] ram, input logic [7:0] region);
    return {slot, vec, op, chk, cmp, mapper, maker, ct, rom, ram, region};
  endfunction

  // plausible header with random content, aimed at the scoring terms
  function automatic record_t shaped_record(input logic [1:0] slot);
    record_t r;
    int      idx;
    r = '0;
    r.slot = slot;
    r.reset_vector = ($urandom_range(9) != 0) ? 16'($urandom_range(16'hffff, 16'h8000))
                                              : 16'($urandom);
    idx = $urandom_range(OPCODE_COUNT - 1);
    r.reset_opcode = ($urandom_range(3) != 0) ? SCORED_OPCODES[idx*8 +: 8] : 8'($urandom);
    r.checksum_word = 16'($urandom);
    r.complement_word = ($urandom_range(9) < 7) ? ~r.checksum_word : 16'($urandom);
    case (slot)
      SLOT_LOW:  r.map_mode = $urandom_range(1) ? 8'h22 : 8'h20;
      SLOT_HIGH: r.map_mode = 8'h21;
      default:   r.map_mode = 8'h25;
    endcase
    // fast rom bit should not matter
    r.map_mode[4] = 1'($urandom);
    if ($urandom_range(4) == 0) r.map_mode = 8'($urandom);
    r.maker_code    = $urandom_range(1) ? 8'h33 : 8'($urandom);
    r.cart_type     = ($urandom_range(9) < 7) ? 8'($urandom_range(15)) : 8'($urandom);
    r.rom_size_code = ($urandom_range(9) < 7) ? 8'($urandom_range(31)) : 8'($urandom);
    r.ram_size_code = ($urandom_range(9) < 7) ? 8'($urandom_range(15)) : 8'($urandom);
    r.region_code   = ($urandom_range(9) < 7) ? 8'($urandom_range(27)) : 8'($urandom);
    return r;
  endfunction

  function automatic record_t noise_record();
    logic [127:0] bits;
    record_t      r;
    bits = {$urandom, $urandom, $urandom, $urandom};
    r = bits[$bits(record_t)-1:0];
    return r;
  endfunction

  initial begin : stimulus
    logic [SIZE_W-1:0] sizes [PHASES];
    int                sent;
    rst       <= 1'b1;
    cfg_wen   <= 1'b0;
    cfg_wdata <= '0;
    quiet     <= 1'b0;
    hold_go   <= 1'b0;
    rec_ch.valid <= 1'b0;
    put_fields('0);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed records with every header in range
    write_size(24'hffffff);
    send_record(header_rec(SLOT_LOW, 16'h8000, 8'h78, 16'h1234, 16'hedcb, 8'h20, 8'h33,
                           8'h07, 8'h0f, 8'h07, 8'h0d));
    send_record(header_rec(SLOT_HIGH, 16'hffff, 8'h5c, 16'hffff, 16'h0000, 8'h31, 8'h00,
                           8'h08, 8'h10, 8'h08, 8'h0e));
    send_record(header_rec(SLOT_EXT, 16'h7fff, 8'h78, 16'h1234, 16'hedcb, 8'h25, 8'h33,
                           8'h00, 8'h00, 8'h00, 8'h00));
    send_record(header_rec(SLOT_LOW, 16'h0000, 8'h18, 16'h5555, 16'haaaa, 8'h22, 8'h33,
                           8'h00, 8'h00, 8'h00, 8'h00));
    send_record(header_rec(SLOT_HIGH, 16'hc000, 8'h20, 16'h0001, 16'hfffe, 8'h21, 8'h33,
                           8'h00, 8'h00, 8'h00, 8'h00));
    // extended score plus bonus ties the high score
    send_record(header_rec(SLOT_EXT, 16'h8000, 8'h22, 16'h8000, 16'h7fff, 8'h35, 8'h33,
                           8'hff, 8'hff, 8'hff, 8'hff));
    send_record(header_rec(SLOT_EXT, 16'hffff, 8'h9c, 16'haaaa, 16'h5555, 8'h25, 8'h33,
                           8'h01, 8'h02, 8'h03, 8'h04));
    // negative totals clamp at zero; both words 0xffff sum past 16 bits
    send_record(header_rec(SLOT_LOW, 16'h8000, 8'hff, 16'hffff, 16'hffff, 8'h22, 8'h00,
                           8'hff, 8'hff, 8'hff, 8'hff));
    send_record(header_rec(SLOT_HIGH, 16'h8000, 8'h6b, 16'h0000, 16'hffff, 8'h21, 8'h00,
                           8'h00, 8'hff, 8'hff, 8'hff));
    send_record(header_rec(SLOT_EXT, 16'h8000, 8'h40, 16'h0000, 16'h0000, 8'h25, 8'h33,
                           8'h00, 8'hff, 8'hff, 8'hff));
    send_record(header_rec(SLOT_EXT, 16'h8001, 8'h60, 16'h0000, 16'h0000, 8'h00, 8'h00,
                           8'hff, 8'hff, 8'hff, 8'hff));
    send_record(header_rec(SLOT_UNUSED, 16'hffff, 8'h78, 16'h1234, 16'hedcb, 8'h25, 8'h33,
                           8'h00, 8'h00, 8'h00, 8'h00));
    send_record(header_rec(SLOT_EXT, 16'h9000, 8'h4c, 16'h0000, 16'h0000, 8'h00, 8'h00,
                           8'hff, 8'hff, 8'hff, 8'hff));
    send_record(header_rec(SLOT_LOW, 16'ha000, 8'h38, 16'h7fff, 16'h8000, 8'h30, 8'h33,
                           8'h0d, 8'h0e, 8'h05, 8'h0c));
    send_record(header_rec(SLOT_HIGH, 16'hb000, 8'hc2, 16'hff00, 16'h00ff, 8'h21, 8'h33,
                           8'h00, 8'h00, 8'h00, 8'h00));
    send_record(header_rec(SLOT_EXT, 16'he000, 8'he2, 16'h0f0f, 16'hf0f0, 8'h25, 8'h00,
                           8'h07, 8'h0f, 8'h07, 8'h0d));
    send_record(header_rec(SLOT_LOW, 16'hffff, 8'had, 16'h0000, 16'h0000, 8'h00, 8'h00,
                           8'h08, 8'h10, 8'h08, 8'h0e));
    send_record(header_rec(SLOT_HIGH, 16'hffff, 8'hcd, 16'h0000, 16'h0000, 8'h00, 8'h00,
                           8'hff, 8'hff, 8'hff, 8'hff));
    send_record(header_rec(SLOT_EXT, 16'h8000, 8'h02, 16'h0000, 16'h0000, 8'h00, 8'h00,
                           8'hff, 8'hff, 8'hff, 8'hff));
    send_record(header_rec(SLOT_LOW, 16'h8000, 8'hdb, 16'h0000, 16'h0000, 8'h00, 8'h00,
                           8'hff, 8'hff, 8'hff, 8'hff));
    send_record(header_rec(SLOT_HIGH, 16'h8000, 8'h42, 16'h0000, 16'h0000, 8'h00, 8'h00,
                           8'hff, 8'hff, 8'hff, 8'hff));
    send_record(header_rec(SLOT_EXT, 16'hffff, 8'hff, 16'hffff, 16'hffff, 8'hff, 8'hff,
                           8'hff, 8'hff, 8'hff, 8'hff));
    rec_ch.valid <= 1'b0;
    settle(4);

    // image sizes around each header location, then random and empty
    sizes = '{24'hffffff, 24'h410000, 24'h40ffff, 24'hffffff, 24'h010000,
              24'h00ffff, 24'h008000, 24'h007fff, 24'h000000, 24'h000000};
    sizes[PHASES-2] = 24'($urandom);
    for (int p = 0; p < PHASES; p++) begin
      write_size(sizes[p]);
      // phase 3 runs without gaps and with the long result hold-off
      quiet   <= (p == 3);
      hold_go <= hold_go || (p == 3);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(4) != 0) begin
          send_record(shaped_record(SLOT_LOW));
          send_record(shaped_record(SLOT_HIGH));
          send_record(shaped_record(SLOT_EXT));
          sent += 3;
        end else begin
          send_record(noise_record());
          sent++;
        end
      end
      rec_ch.valid <= 1'b0;
      settle(4);
    end

    settle(8);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
src/chs_pkg.sv
src/chs_if.sv
src/chs_rater.sv
src/chs_chooser.sv
src/cartridge_header_scorer.sv
tb/sv/chs_score_checker.sv
tb/sv/testbench.sv
